### design/bpts_pkg.sv
// Shared types and constants of the bitmap priority task scheduler.
`timescale 1ns / 1ps

package bpts_pkg;

  // Field widths fixed by the channel format.
  localparam int PRIO_W     = 6;
  localparam int TAG_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int OUT_PRIO_W = 5;

  // Defaults of the top-level parameters.
  localparam int LEVELS_DEF     = 32;
  localparam int POOL_SLOTS_DEF = 64;
  localparam int TAG_BITS_DEF   = 16;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXECUTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Operation class decided by the front.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_EXEC,
    OP_INVALID
  } op_t;

  // One queued request.
  typedef struct packed {
    op_t               op;
    logic [PRIO_W-1:0] lvl;
    logic [TAG_W-1:0]  tag;
  } q_item_t;

endpackage

### design/bpts_front.sv
// Front end: takes input beats, classifies them and hands them to the queue.
`timescale 1ns / 1ps

module bpts_front #(
  parameter int LEVELS = bpts_pkg::LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [bpts_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic [bpts_pkg::TAG_W-1:0]     in_task_tag,
  output logic                           push_valid,
  input  logic                           push_ready,
  output bpts_pkg::q_item_t              push_data
);

  logic              hold_valid_r;
  logic              hold_valid_nxt;
  bpts_pkg::q_item_t hold_r;
  bpts_pkg::q_item_t hold_nxt;
  logic              prio_ok;

  // One extra bit so that a level count of 64 still compares correctly.
  assign prio_ok = ({1'b0, in_priority_req} < (bpts_pkg::PRIO_W + 1)'(LEVELS));

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (hold_valid_r && push_ready) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
      hold_nxt.lvl   = in_priority_req;
      hold_nxt.tag   = in_task_tag;
      if (in_mode) begin
        hold_nxt.op = bpts_pkg::OP_EXEC;
      end else if (prio_ok) begin
        hold_nxt.op = bpts_pkg::OP_INSERT;
      end else begin
        hold_nxt.op = bpts_pkg::OP_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

### design/bpts_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module bpts_queue #(
  parameter int DEPTH = bpts_pkg::Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  bpts_pkg::q_item_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bpts_pkg::q_item_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bpts_pkg::q_item_t entry_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW-1:0]     rd_ptr_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/bpts_back.sv
// Back end: level bitmap, per-level stacks in a linked slot pool, result register.
`timescale 1ns / 1ps

module bpts_back #(
  parameter int LEVELS     = bpts_pkg::LEVELS_DEF,
  parameter int POOL_SLOTS = bpts_pkg::POOL_SLOTS_DEF,
  parameter int TAG_BITS   = bpts_pkg::TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  bpts_pkg::q_item_t                 pop_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpts_pkg::STATUS_W-1:0]     out_status,
  output logic [bpts_pkg::TAG_W-1:0]        out_tag,
  output logic [bpts_pkg::OUT_PRIO_W-1:0]   out_priority
);

  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int FW  = $clog2(POOL_SLOTS + 1);
  localparam int TSW = (TAG_BITS < bpts_pkg::TAG_W) ? TAG_BITS : bpts_pkg::TAG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_W,
    S_EXE_RD,
    S_EXE_W
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bpts_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [bpts_pkg::TAG_W-1:0]      out_tag_r, out_tag_nxt;
  logic [bpts_pkg::OUT_PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [LEVELS-1:0]               bitmap_r, bitmap_nxt;
  logic [SW-1:0]                   free_head_r, free_head_nxt;
  logic [FW-1:0]                   free_cnt_r, free_cnt_nxt;
  logic [FW-1:0]                   fresh_r, fresh_nxt;
  logic [LW-1:0]                   lvl_r, lvl_nxt;
  logic [TSW-1:0]                  tag_r, tag_nxt;

  // Memories: level heads, slot links with a bottom-of-stack flag, slot tags.
  logic [SW-1:0]  lh_mem [LEVELS];
  logic [SW:0]    sn_mem [POOL_SLOTS];
  logic [TSW-1:0] st_mem [POOL_SLOTS];
  logic [SW-1:0]  lh_rd_r;
  logic [SW:0]    sn_rd_r;
  logic [TSW-1:0] st_rd_r;

  logic           lh_re, lh_we;
  logic [LW-1:0]  lh_raddr;
  logic [SW-1:0]  lh_wdata;
  logic           slot_re, sn_we, st_we;
  logic [SW-1:0]  slot_raddr, slot_waddr;
  logic [SW:0]    sn_wdata;

  logic           out_free;
  logic           take;
  logic [LW-1:0]  p_enc;
  logic           slot_fresh;
  logic [SW-1:0]  fresh_link;

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == S_IDLE) && out_free;
  assign take      = pop_valid && pop_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_tag      = out_tag_r;
  assign out_priority = out_prio_r;

  // Highest occupied level; later set bits override earlier ones.
  always_comb begin
    p_enc = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (bitmap_r[i]) begin
        p_enc = LW'(i);
      end
    end
  end

  // Slots at or above the fresh mark were never written and still chain in order.
  assign slot_fresh = (FW'(free_head_r) >= fresh_r);
  assign fresh_link = (free_head_r == SW'(POOL_SLOTS - 1)) ? '0 : free_head_r + 1'b1;

  assign lh_raddr   = (pop_data.op == bpts_pkg::OP_INSERT) ? LW'(pop_data.lvl) : p_enc;
  assign slot_raddr = (state_r == S_EXE_RD) ? lh_rd_r : free_head_r;
  assign slot_waddr = (state_r == S_EXE_W) ? lh_rd_r : free_head_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_prio_nxt   = out_prio_r;
    bitmap_nxt     = bitmap_r;
    free_head_nxt  = free_head_r;
    free_cnt_nxt   = free_cnt_r;
    fresh_nxt      = fresh_r;
    lvl_nxt        = lvl_r;
    tag_nxt        = tag_r;
    lh_re          = 1'b0;
    lh_we          = 1'b0;
    lh_wdata       = free_head_r;
    slot_re        = 1'b0;
    sn_we          = 1'b0;
    st_we          = 1'b0;
    sn_wdata       = {1'b0, free_head_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (take) begin
          out_tag_nxt  = '0;
          out_prio_nxt = '0;
          case (pop_data.op)
            bpts_pkg::OP_INSERT: begin
              if (free_cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bpts_pkg::ST_FULL;
              end else begin
                lh_re     = 1'b1;
                slot_re   = 1'b1;
                lvl_nxt   = LW'(pop_data.lvl);
                tag_nxt   = pop_data.tag[TSW-1:0];
                state_nxt = S_INS_W;
              end
            end
            bpts_pkg::OP_EXEC: begin
              if (bitmap_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bpts_pkg::ST_EMPTY;
              end else begin
                lh_re     = 1'b1;
                lvl_nxt   = p_enc;
                state_nxt = S_EXE_RD;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bpts_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_INS_W: begin
        // Push the allocated slot on top of the level's stack.
        sn_we    = 1'b1;
        st_we    = 1'b1;
        lh_we    = 1'b1;
        lh_wdata = free_head_r;
        if (bitmap_r[lvl_r]) begin
          sn_wdata = {1'b0, lh_rd_r};
        end else begin
          sn_wdata = {1'b1, {SW{1'b0}}};
        end
        if (slot_fresh) begin
          free_head_nxt = fresh_link;
          fresh_nxt     = fresh_r + 1'b1;
        end else begin
          free_head_nxt = sn_rd_r[SW-1:0];
        end
        bitmap_nxt[lvl_r] = 1'b1;
        free_cnt_nxt      = free_cnt_r - 1'b1;
        out_valid_nxt     = 1'b1;
        out_status_nxt    = bpts_pkg::ST_INSERTED;
        state_nxt         = S_IDLE;
      end
      S_EXE_RD: begin
        slot_re   = 1'b1;
        state_nxt = S_EXE_W;
      end
      S_EXE_W: begin
        // Pop the top slot and return it to the front of the free list.
        if (sn_rd_r[SW]) begin
          bitmap_nxt[lvl_r] = 1'b0;
        end else begin
          lh_we    = 1'b1;
          lh_wdata = sn_rd_r[SW-1:0];
        end
        sn_we         = 1'b1;
        sn_wdata      = {1'b0, free_head_r};
        free_head_nxt = lh_rd_r;
        if (free_cnt_r < FW'(POOL_SLOTS)) begin
          free_cnt_nxt = free_cnt_r + 1'b1;
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = bpts_pkg::ST_EXECUTED;
        out_tag_nxt    = bpts_pkg::TAG_W'(st_rd_r);
        out_prio_nxt   = bpts_pkg::OUT_PRIO_W'(lvl_r);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bitmap_r    <= '0;
      free_head_r <= '0;
      free_cnt_r  <= FW'(POOL_SLOTS);
      fresh_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bitmap_r    <= bitmap_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
    end
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_prio_r   <= out_prio_nxt;
    lvl_r        <= lvl_nxt;
    tag_r        <= tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (lh_we) begin
      lh_mem[lvl_r] <= lh_wdata;
    end
    if (lh_re) begin
      lh_rd_r <= lh_mem[lh_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sn_we) begin
      sn_mem[slot_waddr] <= sn_wdata;
    end
    if (slot_re) begin
      sn_rd_r <= sn_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[slot_waddr] <= tag_r;
    end
    if (slot_re) begin
      st_rd_r <= st_mem[slot_raddr];
    end
  end

`ifndef SYNTHESIS
  // With no level occupied, every slot must be back on the free list.
  a_empty_all_free: assert property (@(posedge clk) disable iff (!rst_n)
    (bitmap_r == '0) |-> (free_cnt_r == FW'(POOL_SLOTS)))
    else $error("bitmap empty but slots still allocated");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r <= FW'(POOL_SLOTS)) && (fresh_r <= FW'(POOL_SLOTS)))
    else $error("free count or fresh mark out of range");

  // The result register is always free when a multi-cycle operation completes.
  a_out_free_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_W || state_r == S_EXE_W) |-> out_free)
    else $error("result register busy at commit");

  a_insert_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_W) |=> bitmap_r[$past(lvl_r)])
    else $error("inserted level not marked occupied");
`endif

endmodule

### design/bitmap_priority_task_scheduler_unit.sv
// Top level of the bitmap priority task scheduler.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries one request per beat: in_mode 0
// pushes in_task_tag onto the stack of level in_priority_req, in_mode 1 pops the
// newest task of the highest occupied level. Each request returns exactly one
// beat on the result channel (out_valid/out_ready) with out_status, and for an
// executed task its tag and level in out_tag and out_priority (zero otherwise).
// A request passes an input register and a two-entry queue before the back end
// works on it. The back end answers an invalid priority, a full pool or an empty
// scheduler from its idle state; an insert reads the level head and slot link,
// then writes; an execute reads the level head, then the slot link, then writes;
// the registered reads of the level-head and slot-link memories set these steps.
// Reset empties all levels and puts every slot on the free list at once; no
// clearing pass is needed. When the receiver stalls, the result is held in the
// output register, the back end stops taking requests, and the queue and input
// register keep accepting until they fill.
module bitmap_priority_task_scheduler_unit #(
  parameter int LEVELS     = bpts_pkg::LEVELS_DEF,
  parameter int POOL_SLOTS = bpts_pkg::POOL_SLOTS_DEF,
  parameter int TAG_BITS   = bpts_pkg::TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [bpts_pkg::PRIO_W-1:0]       in_priority_req,
  input  logic [bpts_pkg::TAG_W-1:0]        in_task_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpts_pkg::STATUS_W-1:0]     out_status,
  output logic [bpts_pkg::TAG_W-1:0]        out_tag,
  output logic [bpts_pkg::OUT_PRIO_W-1:0]   out_priority
);

  logic              push_valid;
  logic              push_ready;
  bpts_pkg::q_item_t push_data;
  logic              pop_valid;
  logic              pop_ready;
  bpts_pkg::q_item_t pop_data;

  bpts_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .in_task_tag     (in_task_tag),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  bpts_queue #(
    .DEPTH (bpts_pkg::Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bpts_back #(
    .LEVELS     (LEVELS),
    .POOL_SLOTS (POOL_SLOTS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_tag      (out_tag),
    .out_priority (out_priority)
  );

endmodule

### test/tb_bitmap_priority_task_scheduler_unit.sv
// Self-checking testbench of the bitmap priority task scheduler: directed table, then random phases.
`timescale 1ns / 1ps

module tb_bitmap_priority_task_scheduler_unit;
  import bpts_pkg::*;

  localparam int LEVELS    = LEVELS_DEF;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int SLOTS     = POOL_SLOTS_DEF;
  localparam int LIMIT     = 200000;
  localparam int HOLD_AT   = 200;
  localparam int HOLD_CYC  = 400;
  localparam int TAIL_CYC  = 20;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_EXEC   = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [TAG_W-1:0]      tag;
    logic [OUT_PRIO_W-1:0] prio;
  } sched_result_t;

  typedef struct packed {
    logic              mode;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic              typed;
    sched_result_t     res;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NARROW} phase_t;

  localparam int DIR_N = 21;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b1, '{ST_EMPTY,    16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd32, 16'h1234, 1'b1, '{ST_INVALID,  16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd63, 16'hFFFF, 1'b1, '{ST_INVALID,  16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd0,  16'h0000, 1'b1, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd31, 16'hFFFF, 1'b1, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd31, 16'hAAAA, 1'b1, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd63, 16'hFFFF, 1'b1, '{ST_EXECUTED, 16'hAAAA, 5'd31}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b1, '{ST_EXECUTED, 16'hFFFF, 5'd31}},
    '{MODE_EXEC,   6'd31, 16'h5555, 1'b1, '{ST_EXECUTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b1, '{ST_EMPTY,    16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd5,  16'h5555, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd17, 16'h1717, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd5,  16'h0505, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd16, 16'h8000, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_INSERT, 6'd17, 16'h0001, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b0, '{ST_INSERTED, 16'h0000, 5'd0}},
    '{MODE_EXEC,   6'd0,  16'h0000, 1'b1, '{ST_EMPTY,    16'h0000, 5'd0}}
  };

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic                  in_mode         = MODE_INSERT;
  logic [PRIO_W-1:0]     in_priority_req = '0;
  logic [TAG_W-1:0]      in_task_tag     = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [TAG_W-1:0]      out_tag;
  logic [OUT_PRIO_W-1:0] out_priority;

  // Predictor state: one LIFO per level, newest tag at the front.
  logic [LEVELS-1:0] lvl_map = '0;
  logic [TAG_W-1:0]  lvl_stack [LEVELS][$];
  int                slots_free = SLOTS;

  sched_result_t pending_q [$];
  int            errs    = 0;
  int            sent    = 0;
  int            rx_cnt  = 0;
  int            cycles  = 0;
  int            st_seen [5] = '{0, 0, 0, 0, 0};

  bitmap_priority_task_scheduler_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .in_task_tag     (in_task_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_priority    (out_priority)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic sched_predict(input logic m, input logic [PRIO_W-1:0] p,
                               input logic [TAG_W-1:0] t, output sched_result_t r);
    int lv;
    r  = '0;
    lv = -1;
    if (m == MODE_INSERT) begin
      if (p >= LEVELS) begin
        r.status = ST_INVALID;
      end else if (slots_free == 0) begin
        r.status = ST_FULL;
      end else begin
        lvl_stack[p[LVL_W-1:0]].push_front(t);
        lvl_map[p[LVL_W-1:0]] = 1'b1;
        slots_free--;
        r.status = ST_INSERTED;
      end
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (lv < 0 && lvl_map[i]) lv = i;
      end
      if (lv < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_EXECUTED;
        r.tag    = lvl_stack[lv].pop_front();
        r.prio   = lv[OUT_PRIO_W-1:0];
        if (lvl_stack[lv].size() == 0) lvl_map[lv] = 1'b0;
        slots_free++;
      end
    end
  endtask

  // Offers one request and waits until it is accepted; the expectation is queued on acceptance.
  task automatic send_req(input logic m, input logic [PRIO_W-1:0] p, input logic [TAG_W-1:0] t,
                          input logic typed, input sched_result_t typed_res);
    int            gap;
    sched_result_t r;
    gap = (((sent / 50) % 4) == 1) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_priority_req <= p;
    in_task_tag     <= t;
    do @(negedge clk); while (in_ready !== 1'b1);
    sched_predict(m, p, t, r);
    pending_q.push_back(typed ? typed_res : r);
    sent++;
    @(posedge clk);
  endtask

  task automatic run_phase(input phase_t ph, input int n);
    int                roll;
    logic              m;
    logic [PRIO_W-1:0] p;
    logic [TAG_W-1:0]  t;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      t    = TAG_W'($urandom_range(0, 65535));
      p    = PRIO_W'($urandom_range(0, LEVELS - 1));
      m    = MODE_INSERT;
      case (ph)
        PH_FILL: begin
          if (roll < 10) p = PRIO_W'($urandom_range(LEVELS, 63));
        end
        PH_DRAIN: begin
          if (roll >= 5) begin
            m = MODE_EXEC;
            p = PRIO_W'($urandom_range(0, 63));
          end
        end
        PH_NARROW: begin
          // Pile tasks onto a few levels so that the stacks grow deep.
          case ($urandom_range(0, 3))
            0: p = '0;
            1: p = PRIO_W'(LEVELS - 1);
            default: p = PRIO_W'($urandom_range(0, 3));
          endcase
          if (roll < 5) m = MODE_EXEC;
        end
        default: begin
          if (roll < 8) begin
            p = PRIO_W'($urandom_range(LEVELS, 63));
          end else if (roll >= 55) begin
            m = MODE_EXEC;
            p = PRIO_W'($urandom_range(0, 63));
          end
        end
      endcase
      send_req(m, p, t, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, one long hold-off that backs the block up.
  initial begin
    int w;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_cnt == HOLD_AT && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      w = (((rx_cnt / 50) % 4) == 2) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (out_valid !== 1'b1);
      @(posedge clk);
      rx_cnt++;
    end
  end

  // Compare every result beat with the oldest expectation.
  initial begin
    sched_result_t e;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (out_status < 5) st_seen[out_status]++;
        if (pending_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d tag %h prio %0d",
                   $time, out_status, out_tag, out_priority);
          errs++;
        end else begin
          e = pending_q.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errs++;
          end
          if (out_tag !== e.tag) begin
            $display("%0t: tag expected %h actual %h", $time, e.tag, out_tag);
            errs++;
          end
          if (out_priority !== e.prio) begin
            $display("%0t: priority expected %0d actual %0d", $time, e.prio, out_priority);
            errs++;
          end
        end
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
    $display("[bitmap_priority_task_scheduler_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_req(DIR_TAB[i].mode, DIR_TAB[i].prio, DIR_TAB[i].tag, DIR_TAB[i].typed,
               DIR_TAB[i].res);
    end

    run_phase(PH_FILL, 70);
    run_phase(PH_DRAIN, 75);
    run_phase(PH_MIX, 100);
    run_phase(PH_NARROW, 70);
    run_phase(PH_MIX, 90);
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Sent %0d requests; answers: %0d inserted, %0d invalid, %0d executed,",
             sent, st_seen[0], st_seen[1], st_seen[2]);
    $display("%0d empty, %0d pool full, with one %0d-cycle receiver hold-off.",
             st_seen[3], st_seen[4], HOLD_CYC);
    if (errs == 0) begin
      $display("[bitmap_priority_task_scheduler_unit] OK");
    end else begin
      $display("[bitmap_priority_task_scheduler_unit] ERROR");
    end
    $finish;
  end

endmodule
